// ===== sv/cre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cre_pkg: shared types and constants of the clock rate estimator
// Sequencer states, sample status codes and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package cre_pkg;

  // Event kinds carried on the input beat
  localparam logic ACT_BASELINE = 1'b0;
  localparam logic ACT_SAMPLE   = 1'b1;

  // Status returned with every result beat
  typedef enum logic [1:0] {
    STAT_USED        = 2'd0,
    STAT_GAP         = 2'd1,
    STAT_NO_ADVANCE  = 2'd2,
    STAT_BASELINE    = 2'd3
  } sample_status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TIME,
    ST_CHECK,
    ST_ACC_TICK,
    ST_ACC_NANO,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_FINISH,
    ST_OUT
  } cre_state_t;

  // Progress of accepted samples, saturating at two
  localparam logic [1:0] PROG_NONE  = 2'd0;
  localparam logic [1:0] PROG_ONE   = 2'd1;
  localparam logic [1:0] PROG_READY = 2'd2;

  localparam int unsigned NANO_W    = 34;
  localparam int unsigned DIV_STEPS = 64;

  localparam logic [31:0] NS_PER_SEC   = 32'd1000000000;
  localparam logic [63:0] GAP_LIMIT_NS = 64'd10000000000;
  localparam logic [31:0] KHZ_SCALE    = 32'd1000000;
  localparam logic [31:0] RATE_LOW     = 32'd400000;
  localparam logic [31:0] RATE_HIGH    = 32'd10000000;

endpackage
`default_nettype wire

// ===== sv/cre_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cre_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cre_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== sv/clock_rate_estimator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_rate_estimator_core: moving-window counter rate estimator
// Takes sync events (baseline load or sample), keeps windowed sums of elapsed
// ticks and nanoseconds, and reports the counter rate in kHz.
//
//   channel | ports                                    | dir | handshake
//   --------+------------------------------------------+-----+--------------
//   in      | action, counter_value, mono_seconds/_ns  | in  | valid / stall
//   out     | status, rate_khz, rate_valid/_suspect,   | out | valid / stall
//           | generation                               |     |
//
// Steps: baseline load, straight out; rejected sample, time and check; used
// sample without a rate, also accumulate; rate update, also multiply, 64-bit
// restoring divider (one quotient bit a cycle) and finish. One event is in
// flight at a time; in_stall stays high until its result beat has been taken.
// Synchronous active-low reset clears all but the working registers; window
// entries are masked by per-entry valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module clock_rate_estimator_core
  import cre_pkg::*;
#(
  parameter int unsigned WINDOW_SAMPLES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_action,
  input  wire logic [63:0] in_counter_value,
  input  wire logic [31:0] in_mono_seconds,
  input  wire logic [29:0] in_mono_nanoseconds,
  // result channel
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  out_sample_status,
  output      logic [31:0] out_rate_khz,
  output      logic        out_rate_valid,
  output      logic        out_rate_suspect,
  output      logic [31:0] out_generation
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_SAMPLES);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SAMPLES - 1);
  localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

  // Sequencer
  cre_state_t state_r, state_nxt;

  // Event latched at accept
  logic [63:0] cnt_r, cnt_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [29:0] nsec_r, nsec_nxt;

  // Architectural state
  logic [63:0] base_cnt_r, base_cnt_nxt;
  logic [31:0] base_sec_r, base_sec_nxt;
  logic [29:0] base_nsec_r, base_nsec_nxt;
  logic [63:0] tick_sum_r, tick_sum_nxt;
  logic [63:0] nano_sum_r, nano_sum_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [WINDOW_SAMPLES-1:0] win_vld_r, win_vld_nxt;
  logic [1:0]  prog_r, prog_nxt;
  logic [31:0] gen_r, gen_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic        warned_r, warned_nxt;

  // Working registers
  logic [63:0] ticks_r, ticks_nxt;
  logic [NANO_W-1:0] ns_r, ns_nxt;
  logic [63:0] prod_r, prod_nxt;    // product, then dividend / quotient
  logic [63:0] rem_r, rem_nxt;
  logic [5:0]  div_cnt_r, div_cnt_nxt;
  sample_status_t status_r, status_nxt;
  logic        suspect_r, suspect_nxt;

  // Shared multiplier and helpers
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] dsec;
  logic [31:0] ndiff;
  logic [63:0] ns_full;
  logic [64:0] trial;
  logic [31:0] gen_inc;
  logic [63:0] old_tick;
  logic [NANO_W-1:0] old_nano;
  logic [63:0] tick_rd;
  logic [NANO_W-1:0] nano_rd;
  logic        win_we;
  logic        in_acc;

  assign in_acc = in_valid && !in_stall;

  // Window stores: written once per used sample, read at the current slot
  cre_ram #(.WIDTH(64), .DEPTH(WINDOW_SAMPLES)) u_tick_ram (
    .clk     (clk),
    .wr_en   (win_we),
    .wr_addr (slot_r),
    .wr_data (ticks_r),
    .rd_addr (slot_r),
    .rd_data (tick_rd)
  );

  cre_ram #(.WIDTH(NANO_W), .DEPTH(WINDOW_SAMPLES)) u_nano_ram (
    .clk     (clk),
    .wr_en   (win_we),
    .wr_addr (slot_r),
    .wr_data (ns_r),
    .rd_addr (slot_r),
    .rd_data (nano_rd)
  );

  // Entries never written since the last clear read as zero
  assign old_tick = win_vld_r[slot_r] ? tick_rd : 64'd0;
  assign old_nano = win_vld_r[slot_r] ? nano_rd : '0;

  // Multiplier operand select: elapsed seconds, then the two tick-sum halves
  assign dsec = sec_r - base_sec_r;
  always_comb begin
    unique case (state_r)
      ST_MUL_LO: begin
        mul_a = tick_sum_r[31:0];
        mul_b = KHZ_SCALE;
      end
      ST_MUL_HI: begin
        mul_a = tick_sum_r[63:32];
        mul_b = KHZ_SCALE;
      end
      default: begin
        mul_a = dsec;
        mul_b = NS_PER_SEC;
      end
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // Elapsed nanoseconds: dsec * 1e9 + (nsec - base_nsec), modulo 2^64
  assign ndiff   = {2'b00, nsec_r} - {2'b00, base_nsec_r};
  assign ns_full = prod_r + {{32{ndiff[31]}}, ndiff};

  // Divider trial subtract
  assign trial = {rem_r, prod_r[63]} - {1'b0, nano_sum_r};

  assign gen_inc = gen_r + 32'd1;

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sec_nxt       = sec_r;
    nsec_nxt      = nsec_r;
    base_cnt_nxt  = base_cnt_r;
    base_sec_nxt  = base_sec_r;
    base_nsec_nxt = base_nsec_r;
    tick_sum_nxt  = tick_sum_r;
    nano_sum_nxt  = nano_sum_r;
    slot_nxt      = slot_r;
    win_vld_nxt   = win_vld_r;
    prog_nxt      = prog_r;
    gen_nxt       = gen_r;
    rate_nxt      = rate_r;
    warned_nxt    = warned_r;
    ticks_nxt     = ticks_r;
    ns_nxt        = ns_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    status_nxt    = status_r;
    suspect_nxt   = suspect_r;
    win_we        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          suspect_nxt = 1'b0;
          cnt_nxt     = in_counter_value;
          sec_nxt     = in_mono_seconds;
          nsec_nxt    = in_mono_nanoseconds;
          if (in_action == ACT_BASELINE) begin
            // new reference point, window emptied
            base_cnt_nxt  = in_counter_value;
            base_sec_nxt  = in_mono_seconds;
            base_nsec_nxt = in_mono_nanoseconds;
            tick_sum_nxt  = 64'd0;
            nano_sum_nxt  = 64'd0;
            slot_nxt      = '0;
            win_vld_nxt   = '0;
            gen_nxt       = 32'd0;
            status_nxt    = STAT_BASELINE;
            state_nxt     = ST_OUT;
          end else begin
            state_nxt = ST_TIME;
          end
        end
      end

      ST_TIME: begin
        ticks_nxt = cnt_r - base_cnt_r;
        prod_nxt  = mul_p;
        state_nxt = ST_CHECK;
      end

      ST_CHECK: begin
        // classify the sample
        priority if (sec_r == base_sec_r && nsec_r > base_nsec_r) begin
          status_nxt = STAT_USED;
        end else if (sec_r > base_sec_r) begin
          status_nxt = (ns_full > GAP_LIMIT_NS) ? STAT_GAP : STAT_USED;
        end else begin
          status_nxt = STAT_NO_ADVANCE;
        end
        ns_nxt        = ns_full[NANO_W-1:0];
        base_cnt_nxt  = cnt_r;
        base_sec_nxt  = sec_r;
        base_nsec_nxt = nsec_r;
        // generation steps twice per sample and skips zero
        gen_nxt = (gen_inc == 32'hFFFF_FFFF) ? 32'd2 : gen_inc + 32'd1;
        state_nxt = (status_nxt == STAT_USED) ? ST_ACC_TICK : ST_OUT;
      end

      ST_ACC_TICK: begin
        tick_sum_nxt = tick_sum_r + ticks_r - old_tick;
        state_nxt    = ST_ACC_NANO;
      end

      ST_ACC_NANO: begin
        nano_sum_nxt = nano_sum_r + {{(64-NANO_W){1'b0}}, ns_r}
                       - {{(64-NANO_W){1'b0}}, old_nano};
        win_we              = 1'b1;
        win_vld_nxt[slot_r] = 1'b1;
        slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
        if (prog_r == PROG_NONE) begin
          prog_nxt  = PROG_ONE;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MUL_LO;
        end
      end

      ST_MUL_LO: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_HI;
      end

      ST_MUL_HI: begin
        prod_nxt    = prod_r + {mul_p[31:0], 32'd0};
        rem_nxt     = 64'd0;
        div_cnt_nxt = 6'd0;
        state_nxt   = ST_DIV;
      end

      ST_DIV: begin
        // restoring step; a zero divisor yields an all-ones quotient
        if (!trial[64]) begin
          rem_nxt  = trial[63:0];
          prod_nxt = {prod_r[62:0], 1'b1};
        end else begin
          rem_nxt  = {rem_r[62:0], prod_r[63]};
          prod_nxt = {prod_r[62:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 6'd1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        rate_nxt = prod_r[31:0];
        if ((prod_r[31:0] < RATE_LOW || prod_r[31:0] > RATE_HIGH) && !warned_r) begin
          warned_nxt  = 1'b1;
          suspect_nxt = 1'b1;
        end
        prog_nxt  = PROG_READY;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_cnt_r  <= 64'd0;
      base_sec_r  <= 32'd0;
      base_nsec_r <= 30'd0;
      tick_sum_r  <= 64'd0;
      nano_sum_r  <= 64'd0;
      slot_r      <= '0;
      win_vld_r   <= '0;
      prog_r      <= PROG_NONE;
      gen_r       <= 32'd0;
      rate_r      <= 32'd0;
      warned_r    <= 1'b0;
      suspect_r   <= 1'b0;
      status_r    <= STAT_USED;
    end else begin
      state_r     <= state_nxt;
      base_cnt_r  <= base_cnt_nxt;
      base_sec_r  <= base_sec_nxt;
      base_nsec_r <= base_nsec_nxt;
      tick_sum_r  <= tick_sum_nxt;
      nano_sum_r  <= nano_sum_nxt;
      slot_r      <= slot_nxt;
      win_vld_r   <= win_vld_nxt;
      prog_r      <= prog_nxt;
      gen_r       <= gen_nxt;
      rate_r      <= rate_nxt;
      warned_r    <= warned_nxt;
      suspect_r   <= suspect_nxt;
      status_r    <= status_nxt;
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    sec_r     <= sec_nxt;
    nsec_r    <= nsec_nxt;
    ticks_r   <= ticks_nxt;
    ns_r      <= ns_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
  end

  // Handshake and result beat
  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = (state_r == ST_OUT);
  assign out_sample_status = status_r;
  assign out_rate_khz      = rate_r;
  assign out_rate_valid    = (prog_r == PROG_READY);
  assign out_rate_suspect  = suspect_r;
  assign out_generation    = gen_r;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for clock_rate_estimator_core
// Drives sync events (baseline loads, well-formed samples, gaps, clocks that
// stall or step back, and random noise) through the valid/stall input channel.
// A scoreboard class keeps its own copy of the windowed tick and nanosecond
// sums, predicts every result beat and compares it field by field. The sender
// and receiver run through phases with no idling, heavy idling on either side
// and light idling on both.
// ----------------------------------------------------------------------------
module tb;
  import cre_pkg::*;

  localparam int unsigned WIN_DEPTH = 16;

  // One result beat, as predicted
  typedef struct {
    sample_status_t status;
    logic [31:0]    rate_khz;
    logic           rate_valid;
    logic           rate_suspect;
    logic [31:0]    generation;
  } rate_beat_t;

  // Rate predictor and store of pending result beats
  class rate_scoreboard;
    bit [63:0]   base_cnt;
    bit [31:0]   base_sec;
    bit [29:0]   base_nsec;
    bit [63:0]   tick_sum;
    bit [63:0]   nano_sum;
    bit [63:0]   tick_win[WIN_DEPTH];
    bit [33:0]   nano_win[WIN_DEPTH];
    int unsigned slot;
    bit [1:0]    progress;
    bit [31:0]   gen;
    bit [31:0]   rate;
    bit          warned;
    rate_beat_t  expected_q[$];
    int unsigned errors;
    int unsigned beats;
    int unsigned n_base, n_used, n_gap, n_stuck, n_rate, n_all_ones, n_suspect;

    function new();
      base_cnt  = '0;
      base_sec  = '0;
      base_nsec = '0;
      clear_window();
      progress  = PROG_NONE;
      gen       = '0;
      rate      = '0;
      warned    = 1'b0;
      errors    = 0;
      beats     = 0;
      n_base = 0; n_used = 0; n_gap = 0; n_stuck = 0;
      n_rate = 0; n_all_ones = 0; n_suspect = 0;
    endfunction

    function void clear_window();
      tick_sum = '0;
      nano_sum = '0;
      foreach (tick_win[i]) begin
        tick_win[i] = '0;
        nano_win[i] = '0;
      end
      slot = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Work out the result of one accepted input beat
    function void note_event(logic act, logic [63:0] cnt, logic [31:0] sec,
                             logic [29:0] nsec);
      rate_beat_t  want;
      bit [63:0]   ticks;
      bit [63:0]   span;
      bit [63:0]   scaled;
      bit [31:0]   dsec;
      bit [31:0]   gen_next;
      bit [31:0]   khz;
      int unsigned s;
      want.rate_suspect = 1'b0;
      if (act == ACT_BASELINE) begin
        base_cnt  = cnt;
        base_sec  = sec;
        base_nsec = nsec;
        clear_window();
        gen = '0;
        want.status = STAT_BASELINE;
        n_base++;
      end else begin
        ticks = cnt - base_cnt;
        span  = '0;
        // elapsed time; seconds part wraps modulo 2^64 like the counter
        if (sec == base_sec && nsec > base_nsec) begin
          span = 64'(nsec) - 64'(base_nsec);
          want.status = STAT_USED;
        end else if (sec > base_sec) begin
          dsec = sec - base_sec;
          span = 64'(nsec) + (64'(NS_PER_SEC) - 64'(base_nsec))
               + (64'(dsec) - 64'd1) * 64'(NS_PER_SEC);
          if (span > GAP_LIMIT_NS) want.status = STAT_GAP;
          else                     want.status = STAT_USED;
        end else begin
          want.status = STAT_NO_ADVANCE;
        end

        gen = gen + 32'd1;

        // replace the oldest window entry
        if (want.status == STAT_USED) begin
          s = slot;
          tick_sum    = tick_sum + ticks - tick_win[s];
          tick_win[s] = ticks;
          nano_sum    = nano_sum + span - 64'(nano_win[s]);
          nano_win[s] = span[33:0];
          slot = (s + 1 >= WIN_DEPTH) ? 0 : s + 1;
        end

        base_cnt  = cnt;
        base_sec  = sec;
        base_nsec = nsec;

        // second step of the generation, never landing on zero
        gen_next = gen + 32'd1;
        gen = (gen_next == 32'd0) ? 32'd2 : gen_next;

        if (want.status == STAT_USED) begin
          if (progress == PROG_NONE) begin
            progress = PROG_ONE;
          end else begin
            if (nano_sum == 64'd0) begin
              khz = '1;
              n_all_ones++;
            end else begin
              scaled = tick_sum * 64'(KHZ_SCALE);
              khz = 32'(scaled / nano_sum);
            end
            rate = khz;
            n_rate++;
            if ((khz < RATE_LOW || khz > RATE_HIGH) && !warned) begin
              warned = 1'b1;
              want.rate_suspect = 1'b1;
              n_suspect++;
            end
            progress = PROG_READY;
          end
        end

        case (want.status)
          STAT_USED:       n_used++;
          STAT_GAP:        n_gap++;
          STAT_NO_ADVANCE: n_stuck++;
          default: ;
        endcase
      end
      want.rate_khz   = rate;
      want.rate_valid = (progress == PROG_READY);
      want.generation = gen;
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one accepted result beat with the oldest prediction
    task check_result(logic [1:0] st, logic [31:0] khz, logic vld, logic sus,
                      logic [31:0] gnr);
      rate_beat_t want;
      beats++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", beats));
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("beat %0d status %0d, want %s",
                                  beats, st, want.status.name()));
      if (khz !== want.rate_khz)
        report_mismatch($sformatf("beat %0d rate_khz %0d, want %0d",
                                  beats, khz, want.rate_khz));
      if (vld !== want.rate_valid)
        report_mismatch($sformatf("beat %0d rate_valid %b, want %b",
                                  beats, vld, want.rate_valid));
      if (sus !== want.rate_suspect)
        report_mismatch($sformatf("beat %0d rate_suspect %b, want %b",
                                  beats, sus, want.rate_suspect));
      if (gnr !== want.generation)
        report_mismatch($sformatf("beat %0d generation %0d, want %0d",
                                  beats, gnr, want.generation));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = ACT_BASELINE;
  logic [63:0] in_counter_value = '0;
  logic [31:0] in_mono_seconds = '0;
  logic [29:0] in_mono_nanoseconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_sample_status;
  logic [31:0] out_rate_khz;
  logic        out_rate_valid;
  logic        out_rate_suspect;
  logic [31:0] out_generation;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  // stimulus time base: counter reading and monotonic time of the last event
  bit [63:0] src_cnt = '0;
  bit [31:0] src_sec = 32'd1000;
  bit [29:0] src_nsec = '0;
  bit [63:0] src_khz = 64'd1000000;

  rate_scoreboard sb = new();

  clock_rate_estimator_core #(
    .WINDOW_SAMPLES(WIN_DEPTH)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_counter_value    (in_counter_value),
    .in_mono_seconds     (in_mono_seconds),
    .in_mono_nanoseconds (in_mono_nanoseconds),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sample_status   (out_sample_status),
    .out_rate_khz        (out_rate_khz),
    .out_rate_valid      (out_rate_valid),
    .out_rate_suspect    (out_rate_suspect),
    .out_generation      (out_generation)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Result beats are checked as they are taken
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_result(out_sample_status, out_rate_khz, out_rate_valid,
                      out_rate_suspect, out_generation);
  end

  // Present one event and hold it until the block takes it
  task automatic send_event(logic act, logic [63:0] cnt, logic [31:0] sec,
                            logic [29:0] nsec);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_action           <= act;
    in_counter_value    <= cnt;
    in_mono_seconds     <= sec;
    in_mono_nanoseconds <= nsec;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_event(act, cnt, sec, nsec);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Move the time base forward; the counter follows at the session rate
  task automatic advance_time(bit [63:0] dt_ns);
    bit [63:0] total;
    total    = 64'(src_nsec) + dt_ns;
    src_sec  = src_sec + 32'(total / 64'(NS_PER_SEC));
    src_nsec = 30'(total % 64'(NS_PER_SEC));
    src_cnt  = src_cnt + dt_ns * src_khz / 64'(KHZ_SCALE) + 64'($urandom_range(0, 3));
  endtask

  task automatic random_event();
    int unsigned kind;
    int unsigned pick;
    bit [63:0]   dt;
    logic        act;
    logic [63:0] cnt;
    logic [31:0] sec;
    logic [29:0] nsec;
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      // baseline load, often with a fresh time origin and rate
      if ($urandom_range(0, 1)) begin
        src_cnt  = {$urandom, $urandom};
        src_sec  = $urandom_range(0, 32'hFFF0_0000);
        src_nsec = 30'($urandom_range(0, NS_PER_SEC - 1));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)      src_khz = 64'($urandom_range(1, RATE_LOW - 1));
      else if (pick == 1) src_khz = 64'($urandom_range(RATE_HIGH + 1, 50000000));
      else                src_khz = 64'($urandom_range(RATE_LOW, RATE_HIGH));
      send_event(ACT_BASELINE, src_cnt, src_sec, src_nsec);
    end else if (kind < 84) begin
      // well-formed sample
      pick = $urandom_range(0, 99);
      if (pick < 70)      dt = 64'($urandom_range(50000000, NS_PER_SEC - 1));
      else if (pick < 80) dt = 64'($urandom_range(1, 5000));
      else if (pick < 95)
        dt = 64'($urandom_range(1, 9)) * 64'(NS_PER_SEC)
           + 64'($urandom_range(0, NS_PER_SEC - 1));
      else                dt = GAP_LIMIT_NS;
      advance_time(dt);
      send_event(ACT_SAMPLE, src_cnt, src_sec, src_nsec);
    end else if (kind < 90) begin
      // gap over ten seconds
      advance_time(GAP_LIMIT_NS + 64'($urandom_range(1, 32'hFFFF_FFFF)));
      send_event(ACT_SAMPLE, src_cnt, src_sec, src_nsec);
    end else if (kind < 95) begin
      // clock standing still or stepping back
      pick = $urandom_range(0, 2);
      if (pick == 1 && src_nsec > 0)
        src_nsec = 30'($urandom_range(0, src_nsec - 1));
      else if (pick == 2)
        src_sec = src_sec - $urandom_range(1, 3);
      src_cnt = src_cnt + 64'($urandom);
      send_event(ACT_SAMPLE, src_cnt, src_sec, src_nsec);
    end else begin
      // noise: every field random, then carry on from there
      act  = 1'($urandom_range(0, 1));
      cnt  = {$urandom, $urandom};
      sec  = $urandom;
      nsec = 30'($urandom_range(0, 30'h3FFF_FFFF));
      send_event(act, cnt, sec, nsec);
      src_cnt  = cnt;
      src_sec  = sec;
      src_nsec = 30'(nsec % NS_PER_SEC);
    end
  endtask

  // Run limit
  initial begin
    #10000000;
    $display("clock_rate_estimator_core verification failed");
    $finish;
  end

  initial begin
    int unsigned idle_pct[4];
    int unsigned stall_pct[4];
    idle_pct  = '{0, 79, 0, 11};
    stall_pct = '{0, 0, 79, 11};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: status codes, rate limits, wrapping and field extremes
    src_idle_pct   = 25;
    sink_stall_pct = 25;
    send_event(ACT_SAMPLE,   64'd0,       32'd0,  30'd0);        // same instant as reset
    send_event(ACT_SAMPLE,   64'd1000,    32'd0,  30'd1000);     // first used sample
    send_event(ACT_SAMPLE,   64'd2000,    32'd0,  30'd2000);     // first rate, 1 GHz
    send_event(ACT_BASELINE, 64'd0,       32'd10, 30'd0);
    send_event(ACT_SAMPLE,   64'd400000,  32'd10, 30'd1000000);  // lower limit exactly
    send_event(ACT_BASELINE, 64'd0,       32'd20, 30'd0);
    send_event(ACT_SAMPLE,   64'd10000000, 32'd20, 30'd1000000); // upper limit exactly
    send_event(ACT_BASELINE, 64'd0,       32'd30, 30'd0);
    send_event(ACT_SAMPLE,   64'd399999,  32'd30, 30'd1000000);  // first suspect rate
    send_event(ACT_SAMPLE,   64'd400000,  32'd31, 30'd0);        // low again, no flag
    send_event(ACT_SAMPLE,   64'd500000,  32'd29, 30'd5);        // seconds step back
    send_event(ACT_SAMPLE,   64'd500001,  32'd29, 30'd4);        // nanoseconds step back
    send_event(ACT_SAMPLE,   64'd500002,  32'd29, 30'd4);        // no change at all
    send_event(ACT_SAMPLE,   64'd900000,  32'd39, 30'd4);        // exactly ten seconds
    send_event(ACT_SAMPLE,   64'd990000,  32'd49, 30'd5);        // one ns over ten seconds
    // out-of-range nanoseconds baseline, then zero elapsed time: empty ns sum
    send_event(ACT_BASELINE, 64'hFFFF_FFFF_FFFF_FF00, 32'd200, 30'd1000000000);
    send_event(ACT_SAMPLE,   64'h50,      32'd201, 30'd0);
    send_event(ACT_SAMPLE,   '1,          32'd201, 30'h3FFF_FFFF); // product wraps
    send_event(ACT_SAMPLE,   64'd0,       '1,      30'd999999999);
    send_event(ACT_SAMPLE,   64'd1,       '1,      30'd0);
    send_event(ACT_BASELINE, 64'd0,       '1,      30'h3FFF_FFFF);
    send_event(ACT_SAMPLE,   64'd7,       '1,      30'h3FFF_FFFF);
    send_event(ACT_BASELINE, 64'd0,       32'd0,   30'h3FFF_FFFF);
    send_event(ACT_SAMPLE,   64'd9,       32'd1,   30'd0);         // wraps to a gap
    send_event(ACT_BASELINE, 64'd0,       32'd5,   30'd0);
    send_event(ACT_SAMPLE,   64'd1000000000, 32'd5, 30'd1000);     // quotient over 32 bits
    drain();

    // Random phases, each ending with the sender waiting for every result
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_pct[ph];
      sink_stall_pct = stall_pct[ph];
      repeat (200) random_event();
      drain();
    end

    sink_stall_pct = 0;
    repeat (100) @(posedge clk);

    $display("Run covered %0d events: %0d baselines, %0d used, %0d gaps, %0d stuck clocks",
             sb.beats, sb.n_base, sb.n_used, sb.n_gap, sb.n_stuck);
    $display("%0d rate updates, %0d on an empty ns sum, %0d suspect flag(s), %0d errors",
             sb.n_rate, sb.n_all_ones, sb.n_suspect, sb.errors);
    if (sb.errors == 0) begin
      $display("clock_rate_estimator_core verification clean");
    end else begin
      $display("clock_rate_estimator_core verification failed");
    end
    $finish;
  end

endmodule
